// ----- sv/fccm_pkg.sv -----
// shared types and constants of the cluster chain manager
`default_nettype none

package fccm_pkg;

    localparam int CLUSTERS_DEFAULT = 256;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_ADVANCE = 3'd1,
        REQ_READ    = 3'd2,
        REQ_FREE    = 3'd3,
        REQ_COUNT   = 3'd4,
        REQ_CLEAR   = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_IS_FREE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_FREE = 2'd0,
        KIND_EOC  = 2'd1,
        KIND_LINK = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_LINK,
        S_WALK,
        S_DONE
    } fsm_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] result_cluster;
        logic       at_end;
        logic [8:0] chain_count;
    } rsp_t;

endpackage

`default_nettype wire

// ----- sv/fccm_ifs.sv -----
// request and response channel interfaces
`default_nettype none

interface fccm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] cluster;

    modport source (output valid, output req_type, output cluster, input ready);
    modport sink (input valid, input req_type, input cluster, output ready);
endinterface

interface fccm_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] result_cluster;
    logic       at_end;
    logic [8:0] chain_count;

    modport source (output valid, output status, output result_cluster, output at_end,
                    output chain_count, input ready);
    modport sink (input valid, input status, input result_cluster, input at_end,
                  input chain_count, output ready);
endinterface

`default_nettype wire

// ----- sv/fat_cluster_chain_manager.sv -----
// top level of the cluster chain manager: table memory, sequencer and response register
`default_nettype none

// Keeps a file allocation table of CLUSTERS entries in one synchronous RAM (2-bit kind plus
// link). One request is handled at a time and gives exactly one response; the next request
// is taken as soon as the response sits in the output register. After reset the table is
// cleared in a pass over all CLUSTERS entries before the first request is taken; a clear
// request takes the same pass. Start and extend scan the table from entry 0 upward, one
// entry per cycle. Free and count walk the chain one link per cycle. Both rates are set
// by the single read and single write port of the table RAM.
module fat_cluster_chain_manager #(
    parameter int CLUSTERS = fccm_pkg::CLUSTERS_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fccm_req_if.sink    req,
    fccm_rsp_if.source  rsp
);

    import fccm_pkg::*;

    localparam int CW = $clog2(CLUSTERS);
    localparam int EW = CW + 2;

    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [CW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;
    logic          slot_free;
    logic          rsp_load;
    rsp_t          rsp_data;
    logic          out_valid_reg;
    rsp_t          out_data_reg;

    fccm_ram #(
        .WIDTH (EW),
        .DEPTH (CLUSTERS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fccm_ctrl #(
        .CLUSTERS (CLUSTERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .slot_free (slot_free),
        .rsp_load  (rsp_load),
        .rsp_data  (rsp_data)
    );

    assign slot_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_data_reg <= rsp_data;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_data_reg.status;
    assign rsp.result_cluster = out_data_reg.result_cluster;
    assign rsp.at_end         = out_data_reg.at_end;
    assign rsp.chain_count    = out_data_reg.chain_count;

    // one request in flight: an accepted transaction closes the request side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in progress");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> rsp.valid)
        else $error("loaded response not presented");

    a_error_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.chain_count == 9'd0
            && rsp.result_cluster == 8'd0 && !rsp.at_end))
        else $error("error response carries nonzero fields");

endmodule

`default_nettype wire

// ----- sv/fccm_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module fccm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/fccm_ctrl.sv -----
// request sequencer: table clearing, free scan, chain walks and entry updates
`default_nettype none

module fccm_ctrl #(
    parameter int CLUSTERS = fccm_pkg::CLUSTERS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    fccm_req_if.sink                                    req,
    output logic                                        mem_we,
    output logic [$clog2(CLUSTERS)-1:0]                 mem_waddr,
    output logic [$clog2(CLUSTERS)+1:0]                 mem_wdata,
    output logic [$clog2(CLUSTERS)-1:0]                 mem_raddr,
    input  wire logic [$clog2(CLUSTERS)+1:0]            mem_rdata,
    input  wire logic                                   slot_free,
    output logic                                        rsp_load,
    output fccm_pkg::rsp_t                              rsp_data
);

    import fccm_pkg::*;

    localparam int CW = $clog2(CLUSTERS);
    localparam int EW = CW + 2;
    localparam int SW = $clog2(CLUSTERS + 1);
    localparam logic [CW-1:0] LAST = CW'(CLUSTERS - 1);

    fsm_t state_reg, state_next;

    logic [2:0]    req_reg, req_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] clr_addr_reg, clr_addr_next;
    logic          clr_reply_reg, clr_reply_next;
    logic [CW-1:0] scan_addr_reg, scan_addr_next;
    logic          scan_issued_reg, scan_issued_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [CW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] free_reg, free_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [8:0]    cnt_reg, cnt_next;
    rsp_t          res_reg, res_next;
    logic          fwd_hit_reg;
    logic [EW-1:0] fwd_data_reg;

    logic [EW-1:0] d;
    kind_t         d_kind;
    logic [CW-1:0] d_link;
    logic          accept;
    logic          in_range;
    logic          scan_hit;
    logic          scan_full;
    logic          walk_free;
    logic          walk_end;
    logic [SW-1:0] steps_inc;
    logic [8:0]    cnt_inc;

    // a write to the entry read in the same cycle is forwarded to the next one
    assign d         = fwd_hit_reg ? fwd_data_reg : mem_rdata;
    assign d_kind    = kind_t'(d[EW-1 -: 2]);
    assign d_link    = d[CW-1:0];
    assign accept    = req.valid && req.ready;
    assign in_range  = 32'(req.cluster) < 32'(CLUSTERS);
    assign scan_hit  = rd_pend_reg && (d_kind == KIND_FREE);
    assign scan_full = rd_pend_reg && !scan_hit && (rd_addr_reg == LAST);
    assign walk_free = (d_kind == KIND_FREE);
    assign steps_inc = steps_reg + SW'(1);
    assign walk_end  = walk_free || (d_kind != KIND_LINK) || (steps_inc == SW'(CLUSTERS));
    assign cnt_inc   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 9'd1;
    assign rsp_data  = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST)
                begin
                    state_next = clr_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        REQ_START:              state_next = S_SCAN;
                        REQ_ADVANCE, REQ_READ:  state_next = in_range ? S_LOOK : S_DONE;
                        REQ_FREE, REQ_COUNT:    state_next = in_range ? S_WALK : S_DONE;
                        REQ_CLEAR:              state_next = S_CLEAR;
                        default:                state_next = S_DONE;
                    endcase
                end
            end
            S_LOOK:
            begin
                if (d_kind != KIND_FREE && d_kind != KIND_LINK && req_reg == REQ_ADVANCE)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = (req_reg == REQ_ADVANCE) ? S_LINK : S_DONE;
                end
                else if (scan_full)
                begin
                    state_next = S_DONE;
                end
            end
            S_LINK:
            begin
                state_next = S_DONE;
            end
            S_WALK:
            begin
                if (walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // memory port and handshake outputs
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        mem_raddr = scan_addr_reg;
        req.ready = 1'b0;
        rsp_load  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                mem_raddr = CW'(req.cluster);
            end
            S_LOOK:
            begin
                mem_raddr = scan_addr_reg;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg;
                    mem_wdata = {KIND_EOC, {CW{1'b0}}};
                end
            end
            S_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = {KIND_LINK, free_reg};
            end
            S_WALK:
            begin
                mem_raddr = d_link;
                if (!walk_free && req_reg == REQ_FREE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg;
                end
            end
            S_DONE:
            begin
                rsp_load = slot_free;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        req_next         = req_reg;
        cur_next         = cur_reg;
        clr_addr_next    = clr_addr_reg;
        clr_reply_next   = clr_reply_reg;
        scan_addr_next   = scan_addr_reg;
        scan_issued_next = scan_issued_reg;
        rd_pend_next     = rd_pend_reg;
        rd_addr_next     = rd_addr_reg;
        free_next        = free_reg;
        steps_next       = steps_reg;
        cnt_next         = cnt_reg;
        res_next         = res_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + CW'(1);
                if (clr_addr_reg == LAST)
                begin
                    clr_addr_next  = '0;
                    clr_reply_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next         = req.req_type;
                    cur_next         = CW'(req.cluster);
                    res_next         = '0;
                    steps_next       = '0;
                    cnt_next         = '0;
                    scan_addr_next   = '0;
                    scan_issued_next = 1'b0;
                    rd_pend_next     = 1'b0;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        clr_reply_next = 1'b1;
                    end
                    if (!in_range && (req.req_type == REQ_ADVANCE || req.req_type == REQ_READ
                        || req.req_type == REQ_FREE || req.req_type == REQ_COUNT))
                    begin
                        res_next.status = ST_IS_FREE;
                    end
                end
            end
            S_LOOK:
            begin
                if (d_kind == KIND_FREE)
                begin
                    res_next.status = ST_IS_FREE;
                end
                else if (d_kind == KIND_LINK)
                begin
                    res_next.result_cluster = 8'(d_link);
                end
                else if (req_reg == REQ_READ)
                begin
                    res_next.at_end = 1'b1;
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, its data checked in the cycle after
                if (!scan_issued_reg)
                begin
                    rd_pend_next     = 1'b1;
                    rd_addr_next     = scan_addr_reg;
                    scan_addr_next   = scan_addr_reg + CW'(1);
                    scan_issued_next = (scan_addr_reg == LAST);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                if (scan_hit)
                begin
                    res_next.result_cluster = 8'(rd_addr_reg);
                    free_next               = rd_addr_reg;
                end
                else if (scan_full)
                begin
                    res_next.status = ST_NO_FREE;
                end
            end
            S_LINK:
            begin
                res_next = res_reg;
            end
            S_WALK:
            begin
                if (!walk_free)
                begin
                    cnt_next   = cnt_inc;
                    steps_next = steps_inc;
                    cur_next   = d_link;
                end
                if (walk_end)
                begin
                    res_next.chain_count = walk_free ? cnt_reg : cnt_inc;
                    if (walk_free && steps_reg == '0)
                    begin
                        res_next.status = ST_IS_FREE;
                    end
                end
            end
            S_DONE:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            clr_reply_reg   <= 1'b0;
            scan_issued_reg <= 1'b0;
            rd_pend_reg     <= 1'b0;
            fwd_hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            clr_reply_reg   <= clr_reply_next;
            scan_issued_reg <= scan_issued_next;
            rd_pend_reg     <= rd_pend_next;
            fwd_hit_reg     <= mem_we && (mem_waddr == mem_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        cur_reg       <= cur_next;
        scan_addr_reg <= scan_addr_next;
        rd_addr_reg   <= rd_addr_next;
        free_reg      <= free_next;
        steps_reg     <= steps_next;
        cnt_reg       <= cnt_next;
        res_reg       <= res_next;
        fwd_data_reg  <= mem_wdata;
    end

endmodule

`default_nettype wire
